>>> rtl/core/piecewise_linear_map_interpolator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise-linear map interpolator
// Short helpers for clocked implication checks with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_MAP_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_MAP_INTERPOLATOR_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define PLI_ASSERT_SAME(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// condition in this cycle implies consequence in the next cycle
`define PLI_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared field widths, codes and status types of the map interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int CFG_W    = 7;
  localparam int IDX_W    = 6;
  localparam int SEG_W    = 6;
  localparam int REGION_W = 2;

  localparam logic [REGION_W-1:0] REGION_INSIDE = 2'd0;
  localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd1;
  localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // status handed from an interpolation unit to the sequencer
  typedef struct packed {
    logic done;
    logic fault;
  } lerp_status_t;

endpackage

>>> rtl/core/pli_table.sv
// ----------------------------------------------------------------------------
// pli_table
// Breakpoint memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module pli_table #(
  parameter int ENTRIES = 64,
  parameter int CW      = 32,
  parameter int AW      = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic signed [CW-1:0] wpos,
  input  logic signed [CW-1:0] wx,
  input  logic signed [CW-1:0] wy,
  input  logic [AW-1:0]        raddr_a,
  input  logic [AW-1:0]        raddr_b,
  output logic signed [CW-1:0] pos_a,
  output logic signed [CW-1:0] x_a,
  output logic signed [CW-1:0] y_a,
  output logic signed [CW-1:0] pos_b,
  output logic signed [CW-1:0] x_b,
  output logic signed [CW-1:0] y_b
);

  logic signed [CW-1:0] mem_pos [ENTRIES];
  logic signed [CW-1:0] mem_x   [ENTRIES];
  logic signed [CW-1:0] mem_y   [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_pos[waddr] <= wpos;
      mem_x[waddr]   <= wx;
      mem_y[waddr]   <= wy;
    end
  end

  // registered reads at segment start and end
  always_ff @(posedge clk) begin
    pos_a <= mem_pos[raddr_a];
    x_a   <= mem_x[raddr_a];
    y_a   <= mem_y[raddr_a];
    pos_b <= mem_pos[raddr_b];
    x_b   <= mem_x[raddr_b];
    y_b   <= mem_y[raddr_b];
  end

endmodule

>>> rtl/core/pli_div_cell.sv
// ----------------------------------------------------------------------------
// pli_div_cell
// One restoring division step: shifts in a dividend bit, emits a quotient bit.
// ----------------------------------------------------------------------------
module pli_div_cell #(
  parameter int RW = 34,
  parameter int QW = 36
) (
  input  logic [RW-1:0] divisor,
  input  logic [RW-1:0] rem_in,
  input  logic [QW-1:0] low_in,
  output logic [RW-1:0] rem_out,
  output logic [QW-1:0] low_out
);

  logic [RW:0] trial;
  logic [RW:0] diff;
  logic        ge;

  // remainder stays below the divisor, so the trial fits one extra bit
  always_comb begin
    trial   = {rem_in, low_in[QW-1]};
    diff    = trial - {1'b0, divisor};
    ge      = (trial >= {1'b0, divisor});
    rem_out = ge ? diff[RW-1:0] : trial[RW-1:0];
    low_out = {low_in[QW-2:0], ge};
  end

endmodule

>>> rtl/core/pli_lerp.sv
// ----------------------------------------------------------------------------
// pli_lerp
// Linear interpolation on one axis: split multiply, division over a cell
// chain, rounding to nearest and saturation.
// ----------------------------------------------------------------------------
module pli_lerp #(
  parameter int CW        = 32,
  parameter int DIV_CELLS = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic signed [CW-1:0]  q,
  input  logic signed [CW-1:0]  p0,
  input  logic signed [CW-1:0]  p1,
  input  logic signed [CW-1:0]  m0,
  input  logic signed [CW-1:0]  m1,
  output logic signed [CW-1:0]  res,
  output pli_pkg::lerp_status_t status
);

  localparam int DW     = CW + 1;
  localparam int LOB    = (DW + 1) / 2;
  localparam int HIB    = DW - LOB;
  localparam int PW     = 2 * DW;
  localparam int NW     = PW + 1;
  localparam int RW     = DW + 1;
  localparam int QW     = ((CW + 3 + DIV_CELLS - 1) / DIV_CELLS) * DIV_CELLS;
  localparam int DSTEPS = QW / DIV_CELLS;
  localparam int CNT_W  = $clog2(DSTEPS + 1);
  localparam int EW     = QW + 2;

  typedef enum logic [2:0] {
    L_IDLE, L_MUL0, L_MUL1, L_SUM, L_NUM, L_DIV, L_FIN
  } lstate_t;

  lstate_t              state;
  logic signed [DW-1:0] a;
  logic signed [DW-1:0] b;
  logic signed [DW-1:0] den;
  logic signed [CW-1:0] base;
  logic [DW-1:0]        ma;
  logic [DW-1:0]        mb;
  logic [DW-1:0]        ud;
  logic                 neg;
  logic [DW+LOB-1:0]    p_lo;
  logic [DW+HIB-1:0]    p_hi;
  logic [PW-1:0]        prod;
  logic [NW-1:0]        num;
  logic [RW-1:0]        dvs;
  logic                 ovf;
  logic [RW-1:0]        rem;
  logic [QW-1:0]        low;
  logic [CNT_W-1:0]     cnt;
  logic [RW-1:0]        rem_c [DIV_CELLS+1];
  logic [QW-1:0]        low_c [DIV_CELLS+1];
  logic signed [EW-1:0] sum;
  logic signed [EW-1:0] maxv;
  logic signed [EW-1:0] minv;
  logic [QW-1:0]        lim;

  // magnitudes, rounding numerator, saturation bounds and the quotient applied with its sign
  always_comb begin
    ma   = a[DW-1]   ? DW'(-a)   : DW'(a);
    mb   = b[DW-1]   ? DW'(-b)   : DW'(b);
    ud   = den[DW-1] ? DW'(-den) : DW'(den);
    num  = {prod, 1'b0} + NW'(ud);
    maxv = (EW'(1) <<< (CW - 1)) - EW'(1);
    minv = -(EW'(1) <<< (CW - 1));
    lim  = QW'(1) << (CW + 1);
    sum  = neg ? (EW'(base) - $signed({2'b00, low}))
               : (EW'(base) + $signed({2'b00, low}));
  end

  // division cell chain, several quotient bits per cycle
  assign rem_c[0] = rem;
  assign low_c[0] = low;
  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
    pli_div_cell #(.RW(RW), .QW(QW)) u_cell (
      .divisor (dvs),
      .rem_in  (rem_c[k]),
      .low_in  (low_c[k]),
      .rem_out (rem_c[k+1]),
      .low_out (low_c[k+1])
    );
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= L_IDLE;
      status.done  <= 1'b0;
      status.fault <= 1'b0;
    end else begin
      status.done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (go) begin
            a     <= {q[CW-1], q} - {p0[CW-1], p0};
            b     <= {m1[CW-1], m1} - {m0[CW-1], m0};
            den   <= {p1[CW-1], p1} - {p0[CW-1], p0};
            base  <= m0;
            state <= L_MUL0;
          end
        end
        L_MUL0: begin
          neg   <= (a[DW-1] ^ b[DW-1]) ^ den[DW-1];
          p_lo  <= ma * mb[LOB-1:0];
          dvs   <= {ud, 1'b0};
          state <= L_MUL1;
        end
        L_MUL1: begin
          p_hi  <= ma * mb[DW-1:LOB];
          state <= L_SUM;
        end
        L_SUM: begin
          prod  <= PW'(p_lo) + (PW'(p_hi) << LOB);
          state <= L_NUM;
        end
        L_NUM: begin
          ovf   <= ((num >> QW) >= NW'(dvs));
          rem   <= RW'(num >> QW);
          low   <= num[QW-1:0];
          cnt   <= '0;
          state <= L_DIV;
        end
        L_DIV: begin
          rem <= rem_c[DIV_CELLS];
          low <= low_c[DIV_CELLS];
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DSTEPS - 1)) begin
            state <= L_FIN;
          end
        end
        L_FIN: begin
          status.done  <= 1'b1;
          status.fault <= (den == '0);
          if (den == '0 || a == '0 || b == '0) begin
            res <= base;
          end else if (ovf || low > lim) begin
            res <= neg ? CW'(minv) : CW'(maxv);
          end else if (sum > maxv) begin
            res <= CW'(maxv);
          end else if (sum < minv) begin
            res <= CW'(minv);
          end else begin
            res <= CW'(sum);
          end
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/piecewise_linear_map_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_map_interpolator
// Breakpoint table with interval walk and two-axis linear interpolation.
// ----------------------------------------------------------------------------
// A load transaction (mode 0) is written to the table when accepted and leaves
// busy low. A query transaction (mode 1) raises busy, walks the table one
// segment at a time (one registered memory read and one compare), then runs
// both axes in parallel: setup and split multiply, a two-cell division chain,
// rounding and saturation, and a register for the result. The result appears
// on done for exactly one cycle and cannot be stalled; busy drops in that
// cycle.
// ----------------------------------------------------------------------------
module piecewise_linear_map_interpolator #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               config_write,
  input  logic [pli_pkg::CFG_W-1:0]          config_data,
  input  logic                               mode,
  input  logic [pli_pkg::IDX_W-1:0]          load_index,
  input  logic signed [COORD_WIDTH-1:0]      load_position,
  input  logic signed [COORD_WIDTH-1:0]      load_map_x,
  input  logic signed [COORD_WIDTH-1:0]      load_map_y,
  input  logic signed [COORD_WIDTH-1:0]      query_x,
  input  logic [pli_pkg::SEG_W-1:0]          start_segment,
  output logic                               done,
  output logic signed [COORD_WIDTH-1:0]      map_x,
  output logic signed [COORD_WIDTH-1:0]      map_y,
  output logic [pli_pkg::SEG_W-1:0]          segment,
  output logic [pli_pkg::REGION_W-1:0]       region,
  output logic                               divide_fault
);

  localparam int SW    = $clog2(MAX_POINTS);
  localparam int LIMIT = 2 * MAX_POINTS + 2;
  localparam int IT_W  = $clog2(LIMIT + 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CMP, S_LERP, S_WAIT} state_t;

  state_t                        state;
  logic [pli_pkg::CFG_W-1:0]     point_count;
  logic [SW:0]                   n_use;
  logic [SW-1:0]                 last_seg;
  logic [SW-1:0]                 seg;
  logic [IT_W-1:0]               iter;
  logic signed [COORD_WIDTH-1:0] q;
  logic [pli_pkg::REGION_W-1:0]  reg_code;
  logic                          load_we;
  logic                          accept;
  logic                          lerp_go;
  logic signed [COORD_WIDTH-1:0] pos_a;
  logic signed [COORD_WIDTH-1:0] pos_b;
  logic signed [COORD_WIDTH-1:0] x_a;
  logic signed [COORD_WIDTH-1:0] x_b;
  logic signed [COORD_WIDTH-1:0] y_a;
  logic signed [COORD_WIDTH-1:0] y_b;
  logic signed [COORD_WIDTH-1:0] res_x;
  logic signed [COORD_WIDTH-1:0] res_y;
  pli_pkg::lerp_status_t         stat_x;
  pli_pkg::lerp_status_t         stat_y;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign load_we = accept && (mode == pli_pkg::MODE_LOAD) &&
                   (int'(load_index) < MAX_POINTS);
  assign lerp_go = (state == S_LERP);

  // clamp the breakpoint count to the table
  always_comb begin
    if (point_count < pli_pkg::CFG_W'(2)) begin
      n_use = (SW + 1)'(2);
    end else if (int'(point_count) > MAX_POINTS) begin
      n_use = (SW + 1)'(MAX_POINTS);
    end else begin
      n_use = (SW + 1)'(point_count);
    end
    last_seg = SW'(n_use - (SW + 1)'(2));
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= pli_pkg::CFG_W'(2);
    end else if (config_write) begin
      point_count <= config_data;
    end
  end

  pli_table #(.ENTRIES(MAX_POINTS), .CW(COORD_WIDTH), .AW(SW)) u_table (
    .clk     (clk),
    .we      (load_we),
    .waddr   (SW'(load_index)),
    .wpos    (load_position),
    .wx      (load_map_x),
    .wy      (load_map_y),
    .raddr_a (seg),
    .raddr_b (seg + SW'(1)),
    .pos_a   (pos_a),
    .x_a     (x_a),
    .y_a     (y_a),
    .pos_b   (pos_b),
    .x_b     (x_b),
    .y_b     (y_b)
  );

  pli_lerp #(.CW(COORD_WIDTH)) u_lerp_x (
    .clk (clk), .rst (rst), .go (lerp_go), .q (q),
    .p0 (pos_a), .p1 (pos_b), .m0 (x_a), .m1 (x_b),
    .res (res_x), .status (stat_x)
  );

  pli_lerp #(.CW(COORD_WIDTH)) u_lerp_y (
    .clk (clk), .rst (rst), .go (lerp_go), .q (q),
    .p0 (pos_a), .p1 (pos_b), .m0 (y_a), .m1 (y_b),
    .res (res_y), .status (stat_y)
  );

  // interval walk and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && mode == pli_pkg::MODE_QUERY) begin
            q        <= query_x;
            iter     <= '0;
            reg_code <= pli_pkg::REGION_INSIDE;
            if (int'(start_segment) > int'(last_seg)) begin
              seg <= last_seg;
            end else begin
              seg <= SW'(start_segment);
            end
            state <= S_READ;
          end
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (iter == IT_W'(LIMIT)) begin
            state <= S_LERP;
          end else if (q > pos_b) begin
            if (seg == last_seg) begin
              reg_code <= pli_pkg::REGION_ABOVE;
              state    <= S_LERP;
            end else begin
              seg   <= seg + SW'(1);
              iter  <= iter + IT_W'(1);
              state <= S_READ;
            end
          end else if (q < pos_a) begin
            if (seg == '0) begin
              reg_code <= pli_pkg::REGION_BELOW;
              state    <= S_LERP;
            end else begin
              seg   <= seg - SW'(1);
              iter  <= iter + IT_W'(1);
              state <= S_READ;
            end
          end else begin
            state <= S_LERP;
          end
        end
        S_LERP: state <= S_WAIT;
        S_WAIT: begin
          if (stat_x.done) begin
            done         <= 1'b1;
            map_x        <= res_x;
            map_y        <= res_y;
            segment      <= pli_pkg::SEG_W'(seg);
            region       <= reg_code;
            divide_fault <= stat_x.fault | stat_y.fault;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "piecewise_linear_map_interpolator_assert.svh"

  `PLI_ASSERT_NEXT(a_query_busy, clk, rst, accept && mode == pli_pkg::MODE_QUERY, busy)
  `PLI_ASSERT_NEXT(a_load_free, clk, rst, accept && mode == pli_pkg::MODE_LOAD, !busy)
  `PLI_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `PLI_ASSERT_SAME(a_axes_lock, clk, rst, stat_x.done, stat_y.done)

endmodule
